// ===== src/tpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, constants and the sine table of the turtle path interpreter.
// ----------------------------------------------------------------------------
`default_nettype none
package tpi_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR = 3'd4;

    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_DRAW = 4'd1;
    localparam logic [OP_W-1:0] OP_MOVE = 4'd2;
    localparam logic [OP_W-1:0] OP_LEFT = 4'd3;
    localparam logic [OP_W-1:0] OP_RIGHT = 4'd4;
    localparam logic [OP_W-1:0] OP_PUSH = 4'd5;
    localparam logic [OP_W-1:0] OP_POP = 4'd6;
    localparam logic [OP_W-1:0] OP_SHRINK = 4'd7;
    localparam logic [OP_W-1:0] OP_GROW = 4'd8;

    localparam logic [15:0] HEADING_UP = 16'd49152;
    localparam logic [23:0] LEN_MAX = 24'hFFFFFF;
    localparam logic [15:0] SHRINK_Q16 = 16'd58982;
    localparam logic [16:0] GROW_Q16 = 17'd72090;

    localparam logic [31:0] RST_TURN_STEP = 32'd8192;
    localparam logic [31:0] RST_INIT_LEN = 32'd2560;
    localparam logic [31:0] RST_COLOUR = 32'hFFFFFFFF;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [15:0]        turn_step;
        logic [23:0]        initial_length;
        logic [31:0]        colour;
    } t_cfg;

    typedef logic [64:0][15:0] t_qsin;

    function automatic t_qsin build_qsin();
        longint unsigned s;
        longint unsigned c;
        longint unsigned ns;
        t_qsin t;
        s = 64'd0;
        c = 64'd1 << 30;
        t = '0;
        for (int k = 0; k < 64; k++) begin
            ns = (s * 64'd1073418433 + c * 64'd26350943 + (64'd1 << 29)) >> 30;
            if (k < 63) begin
                c = (c * 64'd1073418433 - s * 64'd26350943 + (64'd1 << 29)) >> 30;
            end
            s = ns;
            t[k+1] = 16'((s + (64'd1 << 15)) >> 16);
        end
        t[64] = 16'd16384;
        return t;
    endfunction

    localparam t_qsin QSIN = build_qsin();

endpackage
`default_nettype wire

// ===== src/tpi_ram.sv =====
// ----------------------------------------------------------------------------
// tpi_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/tpi_front.sv =====
// ----------------------------------------------------------------------------
// tpi_front
// Decodes incoming symbols into turtle commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire [7:0]         i_symbol,
    input  wire               i_start,
    output logic              o_cmd_valid,
    input  wire               i_cmd_ready,
    output tpi_pkg::t_cmd     o_cmd
);
    localparam int QD = 4;
    localparam int QA = $clog2(QD);

    tpi_pkg::t_cmd r_q [QD];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;
    tpi_pkg::t_cmd n_cmd;
    logic          w_push, w_pop;

    always_comb begin
        n_cmd.start = i_start;
        case (i_symbol)
            "F", "X", "A", "G", "Y": n_cmd.op = tpi_pkg::OP_DRAW;
            "f":                     n_cmd.op = tpi_pkg::OP_MOVE;
            "+":                     n_cmd.op = tpi_pkg::OP_LEFT;
            "-":                     n_cmd.op = tpi_pkg::OP_RIGHT;
            "[":                     n_cmd.op = tpi_pkg::OP_PUSH;
            "]":                     n_cmd.op = tpi_pkg::OP_POP;
            "!":                     n_cmd.op = tpi_pkg::OP_SHRINK;
            "?":                     n_cmd.op = tpi_pkg::OP_GROW;
            default:                 n_cmd.op = tpi_pkg::OP_NONE;
        endcase
    end

    assign o_ready     = (r_cnt != (QA+1)'(QD));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/tpi_back.sv =====
// ----------------------------------------------------------------------------
// tpi_back
// Carries out queued turtle commands and produces segment results.
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_back #(
    parameter int STACK_DEPTH = tpi_pkg::STACK_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  tpi_pkg::t_cfg      i_cfg,
    input  wire                i_cmd_valid,
    output logic               o_cmd_ready,
    input  tpi_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [159:0]       o_data,
    output logic               o_ovf
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TRIG = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_POPW = 3'd4;

    logic [2:0]         r_state;
    logic signed [31:0] r_px, r_py, r_fx, r_fy;
    logic [15:0]        r_head;
    logic [23:0]        r_len;
    logic [FW-1:0]      r_fill;
    logic               r_ovf, r_start_done, r_draw;
    logic signed [15:0] r_cos, r_sin;
    logic signed [40:0] r_mx, r_my;
    logic               r_out_valid;
    logic [159:0]       r_out_data;
    logic               r_out_ovf;

    logic               w_eff_start, w_take, w_out_free, w_out_set, w_we, w_re;
    logic [AW-1:0]      w_raddr;
    logic [79:0]        w_rdata;
    logic [39:0]        w_shrink;
    logic [40:0]        w_grow;
    logic [24:0]        w_grow_r;
    logic signed [31:0] w_nx, w_ny;

    function automatic logic signed [15:0] coarse(input logic [7:0] idx);
        logic [5:0]         r;
        logic signed [15:0] v;
        r = idx[5:0];
        v = idx[6] ? tpi_pkg::QSIN[7'd64 - {1'b0, r}] : tpi_pkg::QSIN[r];
        return idx[7] ? -v : v;
    endfunction

    function automatic logic signed [15:0] sin_q14(input logic [15:0] h);
        logic signed [15:0] a, b;
        logic signed [25:0] va, dx, fx, v;
        a = coarse(h[15:8]);
        b = coarse(h[15:8] + 8'd1);
        va = 26'(a);
        dx = 26'(b) - 26'(a);
        fx = $signed({18'd0, h[7:0]});
        v = (va <<< 8) + dx * fx + 26'sd128;
        return 16'(v >>> 8);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] p,
                                                   input logic signed [40:0] m);
        logic signed [40:0] d;
        logic signed [41:0] s;
        d = (m + 41'sd8192) >>> 14;
        s = 42'(p) + 42'(d);
        if (s > 42'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(s);
    endfunction

    assign w_eff_start = i_cmd.start && !r_start_done;
    assign w_take      = (r_state == ST_IDLE) && i_cmd_valid && !w_eff_start;
    assign o_cmd_ready = w_take;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_out_set   = (r_state == ST_ADD) && r_draw && w_out_free;
    assign w_we        = w_take && (i_cmd.op == tpi_pkg::OP_PUSH)
                         && (r_fill < FW'(STACK_DEPTH));
    assign w_re        = w_take && (i_cmd.op == tpi_pkg::OP_POP) && (r_fill != '0);
    assign w_raddr     = AW'(r_fill - 1'b1);
    assign w_shrink    = r_len * tpi_pkg::SHRINK_Q16 + 40'd32768;
    assign w_grow      = r_len * tpi_pkg::GROW_Q16 + 41'd32768;
    assign w_grow_r    = w_grow[40:16];
    assign w_nx        = add_sat(r_px, r_mx);
    assign w_ny        = add_sat(r_py, r_my);

    tpi_ram #(.WIDTH(80), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata ({r_px, r_py, r_head}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_TRIG) begin
            r_cos <= sin_q14(r_head + 16'd16384);
            r_sin <= sin_q14(r_head);
        end
        if (r_state == ST_MUL) begin
            r_mx <= $signed({17'd0, r_len}) * 41'(r_cos);
            r_my <= $signed({17'd0, r_len}) * 41'(r_sin);
        end
        if (w_out_set) begin
            r_out_data <= {i_cfg.colour, w_ny, w_nx, r_fy, r_fx};
            r_out_ovf  <= r_ovf;
        end
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_px         <= '0;
            r_py         <= '0;
            r_head       <= tpi_pkg::HEADING_UP;
            r_len        <= '0;
            r_fill       <= '0;
            r_ovf        <= 1'b0;
            r_start_done <= 1'b0;
            r_draw       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && w_eff_start) begin
                        r_px         <= i_cfg.origin_x;
                        r_py         <= i_cfg.origin_y;
                        r_head       <= tpi_pkg::HEADING_UP;
                        r_len        <= i_cfg.initial_length;
                        r_fill       <= '0;
                        r_ovf        <= 1'b0;
                        r_start_done <= 1'b1;
                    end else if (w_take) begin
                        r_start_done <= 1'b0;
                        case (i_cmd.op)
                            tpi_pkg::OP_DRAW, tpi_pkg::OP_MOVE: begin
                                r_draw  <= (i_cmd.op == tpi_pkg::OP_DRAW);
                                r_fx    <= r_px;
                                r_fy    <= r_py;
                                r_state <= ST_TRIG;
                            end
                            tpi_pkg::OP_LEFT:  r_head <= r_head + i_cfg.turn_step;
                            tpi_pkg::OP_RIGHT: r_head <= r_head - i_cfg.turn_step;
                            tpi_pkg::OP_PUSH: begin
                                if (w_we) begin
                                    r_fill <= r_fill + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            tpi_pkg::OP_POP: begin
                                if (w_re) begin
                                    r_fill  <= r_fill - 1'b1;
                                    r_state <= ST_POPW;
                                end
                            end
                            tpi_pkg::OP_SHRINK: r_len <= w_shrink[39:16];
                            tpi_pkg::OP_GROW: begin
                                r_len <= w_grow_r[24] ? tpi_pkg::LEN_MAX : w_grow_r[23:0];
                            end
                            default: r_len <= r_len;
                        endcase
                    end
                end
                ST_TRIG: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_ADD;
                ST_ADD: begin
                    if (!r_draw || w_out_free) begin
                        r_px    <= w_nx;
                        r_py    <= w_ny;
                        r_state <= ST_IDLE;
                    end
                end
                ST_POPW: begin
                    r_px    <= w_rdata[79:48];
                    r_py    <= w_rdata[47:16];
                    r_head  <= w_rdata[15:0];
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_ovf   = r_out_ovf;
endmodule
`default_nettype wire

// ===== src/turtle_path_interpreter.sv =====
// ----------------------------------------------------------------------------
// turtle_path_interpreter
// Interprets a stream of L-system symbols as turtle moves and emits segments.
//
// Channel   Direction  Content
// s_axis    in         tdata: symbol; tuser: start_req
// m_axis    out        tdata: from_x, from_y, to_x, to_y, line_color;
//                      tuser: stack_overflowed
// cfg       in         write enable, register index, 32-bit data
//
// Symbols enter a four-deep queue at one per cycle while the queue has room.
// Turns, pushes, length scaling and ignored symbols run from idle; a pop waits
// for the stack read; a move or draw does table lookup, multiply and saturating
// add in sequence. A start mark restarts the turtle. Reset is synchronous, active
// low. A stalled output holds the executor only when a further draw is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module turtle_path_interpreter #(
    parameter int STACK_DEPTH = tpi_pkg::STACK_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [7:0]                        s_axis_tdata,  // [7:0] symbol
    input  wire [0:0]                        s_axis_tuser,  // [0] start_req
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [31:0] from_x, [63:32] from_y, [95:64] to_x, [127:96] to_y,
    // [159:128] line_color
    output logic [159:0]                     m_axis_tdata,
    output logic [0:0]                       m_axis_tuser,  // [0] stack_overflowed
    input  wire                              i_cfg_we,
    input  wire [tpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [tpi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    tpi_pkg::t_cfg r_cfg;
    tpi_pkg::t_cmd w_cmd;
    logic          w_cmd_valid, w_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
            r_cfg.turn_step      <= tpi_pkg::RST_TURN_STEP[15:0];
            r_cfg.initial_length <= tpi_pkg::RST_INIT_LEN[23:0];
            r_cfg.colour         <= tpi_pkg::RST_COLOUR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpi_pkg::REG_ORIGIN_X:  r_cfg.origin_x       <= i_cfg_data;
                tpi_pkg::REG_ORIGIN_Y:  r_cfg.origin_y       <= i_cfg_data;
                tpi_pkg::REG_TURN_STEP: r_cfg.turn_step      <= i_cfg_data[15:0];
                tpi_pkg::REG_INIT_LEN:  r_cfg.initial_length <= i_cfg_data[23:0];
                tpi_pkg::REG_COLOUR:    r_cfg.colour         <= i_cfg_data;
                default:                r_cfg                <= r_cfg;
            endcase
        end
    end

    tpi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_symbol    (s_axis_tdata),
        .i_start     (s_axis_tuser[0]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    tpi_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_ovf       (m_axis_tuser[0])
    );
endmodule
`default_nettype wire

// ===== src/tpi_checker.sv =====
// ----------------------------------------------------------------------------
// tpi_checker
// Port-level checks of the turtle path interpreter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [159:0] m_axis_tdata,
    input wire [0:0]   m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output request dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Output payload changed while stalled.");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("Output request present after reset.");

    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("Input not ready after reset.");
endmodule

bind turtle_path_interpreter tpi_checker u_tpi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the turtle path interpreter. Symbol requests are fed
// from a queue with random gaps, segments are taken with random stalls, and
// every segment is compared field by field with a behavioural predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

    localparam int DEPTH = tpi_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic       start;
        logic [7:0] symbol;
    } t_sym;

    typedef struct packed {
        logic        ovf;
        logic [31:0] colour;
        logic [31:0] to_y;
        logic [31:0] to_x;
        logic [31:0] from_y;
        logic [31:0] from_x;
    } t_seg;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic i_cfg_we = 1'b0;
    logic [tpi_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [tpi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    turtle_path_interpreter dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    logic signed [31:0] org_x, org_y;
    logic [15:0] turn_amt;
    logic [23:0] len_init;
    logic [31:0] colour;
    logic signed [31:0] px, py;
    logic [15:0] hdg;
    logic [23:0] step_len;
    logic signed [31:0] stk_x [DEPTH];
    logic signed [31:0] stk_y [DEPTH];
    logic [15:0] stk_h [DEPTH];
    int fill;
    logic ovf_seen;
    int qtab [65];

    t_sym pending_syms [$];
    t_seg expected_segs [$];
    int errors = 0;
    int cycles = 0;
    bit feeding_done = 0;
    bit in_taken = 0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic void add_sym(input logic st, input logic [7:0] sy);
        t_sym it;
        it.start = st;
        it.symbol = sy;
        pending_syms.insert(pending_syms.size(), it);
    endfunction

    function automatic void make_table();
        longint unsigned s, c, ns;
        s = 0;
        c = 64'd1 << 30;
        qtab[0] = 0;
        for (int k = 0; k < 64; k++) begin
            ns = (s * 64'd1073418433 + c * 64'd26350943 + (64'd1 << 29)) >> 30;
            if (k < 63) c = (c * 64'd1073418433 - s * 64'd26350943 + (64'd1 << 29)) >> 30;
            s = ns;
            qtab[k+1] = int'((s + (64'd1 << 15)) >> 16);
        end
        qtab[64] = 16384;
    endfunction

    function automatic int coarse(input int idx);
        int r, q, v;
        r = idx & 63;
        q = (idx >> 6) & 3;
        v = (q & 1) ? qtab[64 - r] : qtab[r];
        return (q & 2) ? -v : v;
    endfunction

    function automatic int sine(input logic [15:0] h);
        int a, b, v;
        a = coarse(h[15:8]);
        b = coarse((h[15:8] + 1) & 255);
        v = a * 256 + (b - a) * int'(h[7:0]);
        return (v + 128) >>> 8;
    endfunction

    function automatic logic signed [31:0] move_one(input logic signed [31:0] p,
                                                   input int trig);
        longint prod, sum;
        prod = longint'(step_len) * trig;
        sum = longint'(p) + ((prod + 8192) >>> 14);
        if (sum > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (sum < -64'sd2147483648) return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic void walk();
        int c, s;
        c = sine(hdg + 16'd16384);
        s = sine(hdg);
        px = move_one(px, c);
        py = move_one(py, s);
    endfunction

    function automatic void restart_turtle();
        px = org_x;
        py = org_y;
        hdg = tpi_pkg::HEADING_UP;
        step_len = len_init;
        fill = 0;
        ovf_seen = 0;
    endfunction

    function automatic void interpret(input t_sym it);
        t_seg sg;
        longint unsigned t;
        if (it.start) restart_turtle();
        case (it.symbol)
            "F", "X", "A", "G", "Y": begin
                sg.from_x = px;
                sg.from_y = py;
                walk();
                sg.to_x = px;
                sg.to_y = py;
                sg.colour = colour;
                sg.ovf = ovf_seen;
                expected_segs.insert(expected_segs.size(), sg);
            end
            "f": walk();
            "+": hdg = hdg + turn_amt;
            "-": hdg = hdg - turn_amt;
            "[": begin
                if (fill < DEPTH) begin
                    stk_x[fill] = px;
                    stk_y[fill] = py;
                    stk_h[fill] = hdg;
                    fill++;
                end else begin
                    ovf_seen = 1;
                end
            end
            "]": begin
                if (fill > 0) begin
                    fill--;
                    px = stk_x[fill];
                    py = stk_y[fill];
                    hdg = stk_h[fill];
                end
            end
            "!": step_len = 24'((64'(step_len) * 58982 + 32768) >> 16);
            "?": begin
                t = (64'(step_len) * 72090 + 32768) >> 16;
                step_len = (t > 64'hFFFFFF) ? 24'hFFFFFF : t[23:0];
            end
            default: ;
        endcase
    endfunction

    // Driver.
    int gap = 0;
    int out_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_taken) begin
            end else if (gap > 0) begin
                gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_syms.size() > 0) begin
                t_sym it;
                it = pending_syms.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.symbol;
                s_axis_tuser <= it.start;
                gap = ($urandom_range(0, 9) < 6) ? 0 :
                      ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                      $urandom_range(10, 40);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3) begin
                    out_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                              $urandom_range(10, 40);
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        cycles++;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
            interpret('{start: s_axis_tuser[0], symbol: s_axis_tdata});
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_segs.size() == 0) begin
                report("segment with none expected");
            end else begin
                t_seg e;
                e = expected_segs.pop_front();
                if (m_axis_tdata[31:0] !== e.from_x) report("from_x");
                if (m_axis_tdata[63:32] !== e.from_y) report("from_y");
                if (m_axis_tdata[95:64] !== e.to_x) report("to_x");
                if (m_axis_tdata[127:96] !== e.to_y) report("to_y");
                if (m_axis_tdata[159:128] !== e.colour) report("line_color");
                if (m_axis_tuser[0] !== e.ovf) report("stack_overflowed");
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [tpi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tpi_pkg::REG_ORIGIN_X: org_x = val;
            tpi_pkg::REG_ORIGIN_Y: org_y = val;
            tpi_pkg::REG_TURN_STEP: turn_amt = val[15:0];
            tpi_pkg::REG_INIT_LEN: len_init = val[23:0];
            tpi_pkg::REG_COLOUR: colour = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_syms.size() > 0 || s_axis_tvalid || expected_segs.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        logic [7:0] alpha [12] = '{"F", "X", "A", "G", "Y", "f", "+", "-", "[", "]",
                                   "!", "?"};
        if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
        return alpha[$urandom_range(0, 11)];
    endfunction

    task automatic queue_string(input int n);
        int depth_bias;
        depth_bias = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            t_sym it;
            it.start = (k == 0) || ($urandom_range(0, 199) == 0);
            it.symbol = pick_symbol();
            if (depth_bias == 0 && $urandom_range(0, 2) == 0) it.symbol = "[";
            pending_syms.insert(pending_syms.size(), it);
        end
    endtask

    initial begin
        logic [7:0] directed [24] = '{"F", "+", "F", "-", "-", "F", "f", "F", "[", "+",
                                      "F", "]", "]", "F", "!", "F", "?", "X", "A", "G",
                                      "Y", "Z", 8'h00, 8'hFF};
        int done_items;
        make_table();
        org_x = 0; org_y = 0; turn_amt = 16'd8192; len_init = 24'd2560;
        colour = 32'hFFFFFFFF;
        px = 0; py = 0; hdg = tpi_pkg::HEADING_UP; step_len = 0; fill = 0; ovf_seen = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers first; a draw before any start mark uses zero length.
        add_sym(1'b0, "F");
        foreach (directed[k]) add_sym(k == 1, directed[k]);
        // Stack overflow and length growth.
        add_sym(1'b1, "?");
        repeat (DEPTH + 1) add_sym(1'b0, "[");
        add_sym(1'b0, "F");
        drain();

        done_items = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(tpi_pkg::REG_ORIGIN_X, 32'h7FFFFF00);
                    write_reg(tpi_pkg::REG_ORIGIN_Y, 32'h80000000);
                    write_reg(tpi_pkg::REG_TURN_STEP, 32'h0000FFFF);
                    write_reg(tpi_pkg::REG_INIT_LEN, 32'h00FFFFFF);
                    write_reg(tpi_pkg::REG_COLOUR, 32'h0);
                end
                1: begin
                    write_reg(tpi_pkg::REG_ORIGIN_X, 32'h80000000);
                    write_reg(tpi_pkg::REG_ORIGIN_Y, 32'h7FFFFFFF);
                    write_reg(tpi_pkg::REG_TURN_STEP, 32'h0);
                    write_reg(tpi_pkg::REG_INIT_LEN, 32'h0);
                    write_reg(tpi_pkg::REG_COLOUR, 32'hA5A55A5A);
                end
                default: begin
                    write_reg(tpi_pkg::REG_ORIGIN_X, $urandom);
                    write_reg(tpi_pkg::REG_ORIGIN_Y, $urandom);
                    write_reg(tpi_pkg::REG_TURN_STEP, $urandom_range(0, 65535));
                    write_reg(tpi_pkg::REG_INIT_LEN, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 20000));
                    write_reg(tpi_pkg::REG_COLOUR, $urandom);
                end
            endcase
            for (int n = 0; n < 155; ) begin
                int len;
                len = $urandom_range(5, 60);
                queue_string(len);
                n += len;
                done_items += len;
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
